@@ sv/nni_pkg.sv @@
`default_nettype none

package nni_pkg;

    // Field and register widths fixed by the pixel format and the register map.
    localparam int unsigned RATIO_W  = 15;
    localparam int unsigned DIM_W    = 7;
    localparam int unsigned AREA_W   = 2 * DIM_W;
    localparam int unsigned ACC_W    = RATIO_W + DIM_W;
    localparam int unsigned POS_W    = ACC_W - 7;
    localparam int unsigned PIX_W    = 24;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;

    localparam logic [RATIO_W-1:0] RATIO_MIN   = 15'd256;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 15'd25600;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 15'd256;
    localparam logic [DIM_W-1:0]   DIM_RESET   = 7'd64;
    localparam logic [ACC_W:0]     ROUND_HALF  = 23'd128;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_RATIO  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_line;
        logic       end_of_frame;
    } out_item_t;

    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] pixel;
    } cmd_t;

    // Effective configuration, already clamped, plus the restart strobe.
    typedef struct packed {
        logic               restart;
        logic [RATIO_W-1:0] ratio;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [AREA_W-1:0]  area;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/nni_fifo.sv @@
`default_nettype none

module nni_fifo #(
    parameter int unsigned WIDTH = 25,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             wr_data,
    input  wire logic                         pop,
    output logic      [WIDTH-1:0]             rd_data,
    output logic                              full,
    output logic                              empty,
    output logic      [$clog2(DEPTH+1)-1:0]   count
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/nni_regs.sv @@
`default_nettype none

module nni_regs #(
    parameter int unsigned MAX_WIDTH  = 64,
    parameter int unsigned MAX_HEIGHT = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [nni_pkg::APB_AW-1:0]   paddr,
    input  wire logic [nni_pkg::APB_DW-1:0]   pwdata,
    output logic      [nni_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output nni_pkg::cfg_t                     cfg
);

    import nni_pkg::*;

    localparam int unsigned DIM_LIMIT = (1 << DIM_W) - 1;
    localparam int unsigned W_CAP     = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
    localparam int unsigned H_CAP     = (MAX_HEIGHT < DIM_LIMIT) ? MAX_HEIGHT : DIM_LIMIT;
    localparam int unsigned W_RST     = (W_CAP < 64) ? W_CAP : 64;
    localparam int unsigned H_RST     = (H_CAP < 64) ? H_CAP : 64;

    logic [RATIO_W-1:0] ratio_q8_reg;
    logic [DIM_W-1:0]   source_width_reg;
    logic [DIM_W-1:0]   source_height_reg;
    logic [AREA_W-1:0]  area_reg;
    logic               restart_reg;

    logic               wr_en;
    logic               wr_known;
    logic [1:0]         index;
    logic [RATIO_W-1:0] ratio_eff;
    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        unique case (index)
            REG_RATIO, REG_WIDTH, REG_HEIGHT: wr_known = 1'b1;
            default:                          wr_known = 1'b0;
        endcase
    end

    always_comb begin
        priority if (ratio_q8_reg < RATIO_MIN) begin
            ratio_eff = RATIO_MIN;
        end else if (ratio_q8_reg > RATIO_MAX) begin
            ratio_eff = RATIO_MAX;
        end else begin
            ratio_eff = ratio_q8_reg;
        end
        priority if (source_width_reg == '0) begin
            width_eff = DIM_W'(1);
        end else if (source_width_reg > DIM_W'(W_CAP)) begin
            width_eff = DIM_W'(W_CAP);
        end else begin
            width_eff = source_width_reg;
        end
        priority if (source_height_reg == '0) begin
            height_eff = DIM_W'(1);
        end else if (source_height_reg > DIM_W'(H_CAP)) begin
            height_eff = DIM_W'(H_CAP);
        end else begin
            height_eff = source_height_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_q8_reg      <= RATIO_RESET;
            source_width_reg  <= DIM_RESET;
            source_height_reg <= DIM_RESET;
            area_reg          <= AREA_W'(W_RST * H_RST);
            restart_reg       <= 1'b0;
        end else begin
            restart_reg <= wr_en && wr_known;
            area_reg    <= AREA_W'(width_eff) * AREA_W'(height_eff);
            if (wr_en) begin
                unique case (index)
                    REG_RATIO:  ratio_q8_reg      <= pwdata[RATIO_W-1:0];
                    REG_WIDTH:  source_width_reg  <= pwdata[DIM_W-1:0];
                    REG_HEIGHT: source_height_reg <= pwdata[DIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (index)
            REG_RATIO:  prdata = APB_DW'(ratio_q8_reg);
            REG_WIDTH:  prdata = APB_DW'(source_width_reg);
            REG_HEIGHT: prdata = APB_DW'(source_height_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        cfg.restart = restart_reg;
        cfg.ratio   = ratio_eff;
        cfg.width   = width_eff;
        cfg.height  = height_eff;
        cfg.area    = area_reg;
    end

endmodule

`default_nettype wire

@@ sv/nni_front.sv @@
`default_nettype none

module nni_front #(
    parameter int unsigned STORE_AW = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire nni_pkg::cfg_t          cfg,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire nni_pkg::in_item_t      s_item,
    input  wire logic                   q_full,
    output logic                        q_push,
    output nni_pkg::cmd_t               q_cmd,
    output logic      [STORE_AW-1:0]    q_addr
);

    import nni_pkg::*;

    localparam int unsigned CW = (STORE_AW + 1 > AREA_W) ? STORE_AW + 1 : AREA_W;

    logic [STORE_AW-1:0] load_ptr_reg, load_ptr_next;
    logic [CW-1:0]       ptr_inc;

    // Input is held off for the cycle in which a register write restarts the block.
    assign s_ready = !q_full && !cfg.restart;
    assign q_push  = s_valid && s_ready;
    assign q_addr  = load_ptr_reg;
    assign ptr_inc = CW'(load_ptr_reg) + CW'(1);

    always_comb begin
        q_cmd.op    = s_item.mode ? OP_READ : OP_LOAD;
        q_cmd.pixel = {s_item.red_in, s_item.green_in, s_item.blue_in};
    end

    always_comb begin
        load_ptr_next = load_ptr_reg;
        if (q_push && (q_cmd.op == OP_LOAD)) begin
            load_ptr_next = (ptr_inc >= CW'(cfg.area)) ? '0 : ptr_inc[STORE_AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.restart) begin
            load_ptr_reg <= '0;
        end else begin
            load_ptr_reg <= load_ptr_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/nni_back.sv @@
`default_nettype none

module nni_back #(
    parameter int unsigned STORE_DEPTH = 4096,
    parameter int unsigned STORE_AW    = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire nni_pkg::cfg_t         cfg,
    input  wire logic                  q_empty,
    input  wire nni_pkg::cmd_t         q_cmd,
    input  wire logic [STORE_AW-1:0]   q_addr,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output nni_pkg::out_item_t         m_item
);

    import nni_pkg::*;

    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_CW    = $clog2(OUT_DEPTH + 1);

    logic [PIX_W-1:0]    store_mem [STORE_DEPTH];
    logic [PIX_W-1:0]    rd_data_reg;

    logic [DIM_W-1:0]    src_col_reg,  src_col_next;
    logic [DIM_W-1:0]    src_row_reg,  src_row_next;
    logic [STORE_AW-1:0] row_base_reg, row_base_next;
    logic [POS_W-1:0]    out_col_reg,  out_col_next;
    logic [POS_W-1:0]    out_row_reg,  out_row_next;
    logic [ACC_W-1:0]    col_acc_reg,  col_acc_next;
    logic [ACC_W-1:0]    row_acc_reg,  row_acc_next;
    logic                p1_valid_reg;
    logic                p1_eol_reg,   p1_eol_next;
    logic                p1_eof_reg,   p1_eof_next;

    logic                do_load;
    logic                do_read;
    logic                credit_ok;
    logic [STORE_AW-1:0] rd_addr;
    logic [ACC_W:0]      col_sum;
    logic [ACC_W:0]      row_sum;
    logic [POS_W-1:0]    col_cnt_inc;
    logic [POS_W-1:0]    row_cnt_inc;
    logic                col_hit;
    logic                row_hit;
    logic                col_last;
    logic                row_last;

    out_item_t           out_wr;
    logic [$bits(out_item_t)-1:0] out_rd;
    logic                out_full;
    logic                out_empty;
    logic [OUT_CW-1:0]   out_count;

    // A read may only start if its result is sure of a place in the output queue,
    // counting the one still in the read stage.
    assign credit_ok = !out_full &&
                       ((OUT_CW'(out_count) + OUT_CW'(p1_valid_reg)) < OUT_CW'(OUT_DEPTH));
    assign q_pop     = !q_empty && ((q_cmd.op == OP_LOAD) || credit_ok);
    assign do_load   = q_pop && (q_cmd.op == OP_LOAD);
    assign do_read   = q_pop && (q_cmd.op == OP_READ);
    assign rd_addr   = row_base_reg + STORE_AW'(src_col_reg);

    // Boundaries round half up: (acc + 128) >> 8.
    assign col_sum     = {1'b0, col_acc_reg} + ROUND_HALF;
    assign row_sum     = {1'b0, row_acc_reg} + ROUND_HALF;
    assign col_cnt_inc = out_col_reg + POS_W'(1);
    assign row_cnt_inc = out_row_reg + POS_W'(1);
    assign col_hit     = col_cnt_inc >= col_sum[ACC_W:8];
    assign row_hit     = row_cnt_inc >= row_sum[ACC_W:8];
    assign col_last    = ({1'b0, src_col_reg} + (DIM_W+1)'(1)) >= {1'b0, cfg.width};
    assign row_last    = ({1'b0, src_row_reg} + (DIM_W+1)'(1)) >= {1'b0, cfg.height};

    always_comb begin
        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        row_base_next = row_base_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        col_acc_next  = col_acc_reg;
        row_acc_next  = row_acc_reg;
        p1_eol_next   = 1'b0;
        p1_eof_next   = 1'b0;
        if (do_read) begin
            out_col_next = col_cnt_inc;
            if (col_hit) begin
                if (col_last) begin
                    p1_eol_next  = 1'b1;
                    out_col_next = '0;
                    src_col_next = '0;
                    col_acc_next = ACC_W'(cfg.ratio);
                    out_row_next = row_cnt_inc;
                    if (row_hit) begin
                        if (row_last) begin
                            p1_eof_next   = 1'b1;
                            out_row_next  = '0;
                            src_row_next  = '0;
                            row_base_next = '0;
                            row_acc_next  = ACC_W'(cfg.ratio);
                        end else begin
                            src_row_next  = src_row_reg + DIM_W'(1);
                            row_base_next = row_base_reg + STORE_AW'(cfg.width);
                            row_acc_next  = row_acc_reg + ACC_W'(cfg.ratio);
                        end
                    end
                end else begin
                    src_col_next = src_col_reg + DIM_W'(1);
                    col_acc_next = col_acc_reg + ACC_W'(cfg.ratio);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            row_base_reg <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            col_acc_reg  <= ACC_W'(RATIO_RESET);
            row_acc_reg  <= ACC_W'(RATIO_RESET);
            p1_valid_reg <= 1'b0;
        end else if (cfg.restart) begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            row_base_reg <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            col_acc_reg  <= ACC_W'(cfg.ratio);
            row_acc_reg  <= ACC_W'(cfg.ratio);
            p1_valid_reg <= 1'b0;
        end else begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            row_base_reg <= row_base_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            col_acc_reg  <= col_acc_next;
            row_acc_reg  <= row_acc_next;
            p1_valid_reg <= do_read;
        end
    end

    always_ff @(posedge aclk) begin
        p1_eol_reg <= p1_eol_next;
        p1_eof_reg <= p1_eof_next;
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            store_mem[q_addr] <= q_cmd.pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_read) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb begin
        out_wr.red_out      = rd_data_reg[23:16];
        out_wr.green_out    = rd_data_reg[15:8];
        out_wr.blue_out     = rd_data_reg[7:0];
        out_wr.end_of_line  = p1_eol_reg;
        out_wr.end_of_frame = p1_eof_reg;
    end

    nni_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (p1_valid_reg),
        .wr_data (out_wr),
        .pop     (m_valid && m_ready),
        .rd_data (out_rd),
        .full    (out_full),
        .empty   (out_empty),
        .count   (out_count)
    );

    assign m_valid = !out_empty;
    assign m_item  = out_item_t'(out_rd);

endmodule

`default_nettype wire

@@ sv/nearest_neighbor_image_upscaler.sv @@
// A pixel request goes through the command queue, read stage and output queue to m_valid.
// Throughput: one request per cycle in steady state while the output queue has room, set
// by the single store port and the back sequencer, which does one request each cycle.
// A known register write lowers s_ready for one cycle as position and load state restart.
// Reset is synchronous and active low; it clears control state and the queues, and the
// frame store keeps whatever it held, so no clearing pass follows reset.
`default_nettype none

module nearest_neighbor_image_upscaler #(
    parameter int unsigned MAX_WIDTH  = 64,
    parameter int unsigned MAX_HEIGHT = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire nni_pkg::in_item_t            s_item,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output nni_pkg::out_item_t                m_item,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [nni_pkg::APB_AW-1:0]   paddr,
    input  wire logic [nni_pkg::APB_DW-1:0]   pwdata,
    output logic      [nni_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    import nni_pkg::*;

    // The frame store holds the largest image the parameters allow. Every address the
    // block forms stays below width times height, so no wrap on the depth is needed.
    localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned CMD_DEPTH   = 4;
    localparam int unsigned CMD_W       = $bits(cmd_t) + STORE_AW;

    cfg_t                cfg;
    cmd_t                front_cmd;
    logic [STORE_AW-1:0] front_addr;
    logic                front_push;
    cmd_t                back_cmd;
    logic [STORE_AW-1:0] back_addr;
    logic                back_pop;
    logic [CMD_W-1:0]    q_wr_data;
    logic [CMD_W-1:0]    q_rd_data;
    logic                q_full;
    logic                q_empty;
    logic [$clog2(CMD_DEPTH+1)-1:0] q_count;

    // Register file: the scale ratio and the source size, clamped to their legal
    // ranges before anything downstream sees them. A write to a known register
    // raises a one-cycle restart strobe.
    nni_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: accepts each request, sorts it into a load or a read, and gives every
    // load its place in the frame store from the raster load pointer.
    nni_front #(
        .STORE_AW (STORE_AW)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (front_push),
        .q_cmd   (front_cmd),
        .q_addr  (front_addr)
    );

    // The command queue decouples the front from the back, so that a stalled output
    // side does not stop loads being taken in until the queue fills.
    assign q_wr_data              = {front_addr, front_cmd};
    assign {back_addr, back_cmd}  = q_rd_data;

    nni_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_push),
        .wr_data (q_wr_data),
        .pop     (back_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty),
        .count   (q_count)
    );

    // Back: writes loads into the frame store, and for each read forms the address of
    // the covering source pixel, steps the Q14.8 column and row boundary accumulators,
    // and passes the pixel with its line and frame flags through a small output queue.
    nni_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .STORE_AW    (STORE_AW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty || (q_count == '0)),
        .q_cmd   (back_cmd),
        .q_addr  (back_addr),
        .q_pop   (back_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

@@ sv/nni_checker.sv @@
`default_nettype none

module nni_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire nni_pkg::in_item_t            s_item,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire nni_pkg::out_item_t           m_item,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic [nni_pkg::APB_AW-1:0]   paddr,
    input wire logic [nni_pkg::APB_DW-1:0]   pwdata,
    input wire logic [nni_pkg::APB_DW-1:0]   prdata,
    input wire logic                         pready
);

    import nni_pkg::*;

    // A result that is not taken stays offered and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("result request changed or dropped while stalled");

    // The last pixel of a frame is always the last pixel of its row.
    a_eof_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.end_of_frame) |-> m_item.end_of_line)
        else $error("end of frame without end of line");

    // No result is offered straight after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // A write to a known register holds the input off for the restart cycle.
    a_restart_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready &&
         ((paddr[3:2] == REG_RATIO) || (paddr[3:2] == REG_WIDTH) ||
          (paddr[3:2] == REG_HEIGHT))) |=> !s_ready)
        else $error("input accepted during restart");

endmodule

bind nearest_neighbor_image_upscaler nni_checker u_nni_checker (.*);

`default_nettype wire
